### rtl/core/pzsl_pkg.sv
// ----------------------------------------------------------------------------
// pzsl_pkg
// Shared types and constants of the proximity zone speed limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pzsl_pkg;

	// field and register widths
	localparam int REG_W     = 13;
	localparam int COORD_W   = 16;
	localparam int VEL_W     = 16;
	localparam int CL_W      = 17;
	localparam int REQ_W     = 2;
	localparam int CFG_IDX_W = 3;
	localparam int ZONE_N    = 4;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 56;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POINT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_VEL   = 2'd2;

	// zone indices
	localparam logic [1:0] ZN_FRONT = 2'd0;
	localparam logic [1:0] ZN_REAR  = 2'd1;
	localparam logic [1:0] ZN_LEFT  = 2'd2;
	localparam logic [1:0] ZN_RIGHT = 2'd3;

	// configuration register indices
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_DIST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DIST   = 3'd3;

	// configuration reset values
	localparam logic [REG_W-1:0] RST_HALF_LENGTH = 13'd250;
	localparam logic [REG_W-1:0] RST_HALF_WIDTH  = 13'd200;
	localparam logic [REG_W-1:0] RST_REDUCE_DIST = 13'd500;
	localparam logic [REG_W-1:0] RST_ZERO_DIST   = 13'd100;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZONE,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/core/pzsl_div.sv
// ----------------------------------------------------------------------------
// pzsl_div
// Restoring divider giving floor((num << QW) / den) for num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pzsl_div #(
	parameter int QW = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pzsl_pkg::REG_W-1:0] num,
	input  wire logic [pzsl_pkg::REG_W-1:0] den,
	output logic                           done,
	output logic [QW-1:0]                  quot
);

	localparam int CW = $clog2(QW + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CW-1:0]              cnt_q;
	logic [pzsl_pkg::REG_W-1:0] rem_q;
	logic [pzsl_pkg::REG_W-1:0] den_q;
	logic [QW-1:0]              quot_q;
	logic [pzsl_pkg::REG_W:0]   shifted;
	logic                       fits;

	// one restoring step
	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= pzsl_pkg::REG_W'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[pzsl_pkg::REG_W-1:0];
			end
			quot_q <= {quot_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

### rtl/core/proximity_zone_speed_limiter.sv
// ----------------------------------------------------------------------------
// proximity_zone_speed_limiter
// Tracks four clearance boxes around a robot body and limits velocity
// commands by the smallest speed factor found in each hit box.
// ----------------------------------------------------------------------------
// Takes one request at a time; s_axis_tready is high only while the sequencer
// is idle. A begin request is handled while the sequencer stays idle. An
// obstacle point is accepted and then each box is tested in turn; a box whose
// clearance lies strictly between zero_distance and reduce_distance also
// takes its factor through the single bit-serial divider before the next box.
// A velocity command is accepted, makes three passes through the one shared
// multiplier and then loads the result register, which holds the result while
// the next request is taken; that load waits for as long as an earlier result
// is still unaccepted. Speed factors are unsigned Q1.FACTOR_BITS.
`default_nettype none

module proximity_zone_speed_limiter #(
	parameter int FACTOR_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [pzsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pzsl_pkg::REG_W-1:0]           cfg_data,
	// request stream
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// point_x, point_y, cmd_vx, cmd_vy, cmd_yaw
	input  wire logic [pzsl_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// req_type
	input  wire logic [pzsl_pkg::REQ_W-1:0]           s_axis_tuser,
	// result stream
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// out_vx, out_vy, out_yaw, zone_hits, zero fill
	output logic [pzsl_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

	localparam int FW = FACTOR_BITS + 1;
	localparam int PW = pzsl_pkg::VEL_W + FW;
	localparam logic [FW-1:0] FACTOR_ONE = {1'b1, {FACTOR_BITS{1'b0}}};
	localparam int CL_W  = pzsl_pkg::CL_W;
	localparam int REG_W = pzsl_pkg::REG_W;
	localparam int VEL_W = pzsl_pkg::VEL_W;

	pzsl_pkg::state_t state_q, state_d;

	logic [REG_W-1:0] hl_q, hw_q, rd_q, zd_q;

	logic signed [VEL_W-1:0] px_q, py_q, vx_q, vy_q, yaw_q;
	logic [FW-1:0]           fx_q, fy_q, fa_q;

	logic          zone_hit_q    [pzsl_pkg::ZONE_N];
	logic [FW-1:0] zone_factor_q [pzsl_pkg::ZONE_N];
	logic [1:0]    zone_q;

	logic [1:0]       mul_cnt_q;
	logic [VEL_W-1:0] mag_q [3];

	logic                                m_valid_q;
	logic [pzsl_pkg::OUT_DATA_W-1:0]     m_data_q;

	logic                    accept;
	logic [pzsl_pkg::REQ_W-1:0] req;
	logic signed [VEL_W-1:0] in_vx, in_vy;

	logic signed [CL_W-1:0] xs, ys, hl_s, hw_s, rd_s;
	logic signed [CL_W-1:0] clr, lat, lat_h;
	logic                   in_box, zero_hit, full_hit, need_div;
	logic [REG_W-1:0]       gap;

	logic                   div_start, div_done;
	logic [FACTOR_BITS-1:0] div_quot;

	logic          upd_en, zone_adv, out_load;
	logic [FW-1:0] upd_f;

	logic [FW-1:0]           fx, fy, fa;
	logic signed [VEL_W-1:0] v_sel;
	logic [FW-1:0]           f_sel;
	logic [VEL_W-1:0]        mag;
	logic [PW-1:0]           prod;
	logic [VEL_W-1:0]        res_vx, res_vy, res_yaw;
	logic [pzsl_pkg::ZONE_N-1:0] hits;

	// request handshake
	assign s_axis_tready = (state_q == pzsl_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req           = s_axis_tuser;
	assign in_vx         = $signed(s_axis_tdata[47:32]);
	assign in_vy         = $signed(s_axis_tdata[63:48]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= pzsl_pkg::RST_HALF_LENGTH;
			hw_q <= pzsl_pkg::RST_HALF_WIDTH;
			rd_q <= pzsl_pkg::RST_REDUCE_DIST;
			zd_q <= pzsl_pkg::RST_ZERO_DIST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pzsl_pkg::CFG_HALF_LENGTH: hl_q <= cfg_data;
				pzsl_pkg::CFG_HALF_WIDTH:  hw_q <= cfg_data;
				pzsl_pkg::CFG_REDUCE_DIST: rd_q <= cfg_data;
				pzsl_pkg::CFG_ZERO_DIST:   zd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// box test for the zone under work
	always_comb begin
		xs   = CL_W'(px_q);
		ys   = CL_W'(py_q);
		hl_s = $signed({{(CL_W-REG_W){1'b0}}, hl_q});
		hw_s = $signed({{(CL_W-REG_W){1'b0}}, hw_q});
		rd_s = $signed({{(CL_W-REG_W){1'b0}}, rd_q});
		unique case (zone_q)
			pzsl_pkg::ZN_FRONT: begin
				clr   = xs - hl_s;
				lat   = ys;
				lat_h = hw_s;
			end
			pzsl_pkg::ZN_REAR: begin
				clr   = -hl_s - xs;
				lat   = ys;
				lat_h = hw_s;
			end
			pzsl_pkg::ZN_LEFT: begin
				clr   = ys - hw_s;
				lat   = xs;
				lat_h = hl_s;
			end
			default: begin
				clr   = -hw_s - ys;
				lat   = xs;
				lat_h = hl_s;
			end
		endcase
		in_box   = (clr >= 0) && (clr <= rd_s) && (lat >= -lat_h) && (lat <= lat_h);
		gap      = clr[REG_W-1:0];
		zero_hit = gap <= zd_q;
		full_hit = gap >= rd_q;
		need_div = in_box && !zero_hit && !full_hit;
	end

	// shared divider for the linear part of the factor
	pzsl_div #(
		.QW(FACTOR_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (REG_W'(gap - zd_q)),
		.den   (REG_W'(rd_q - zd_q)),
		.done  (div_done),
		.quot  (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pzsl_pkg::ST_IDLE: begin
				if (accept && req == pzsl_pkg::REQ_POINT) begin
					state_d = pzsl_pkg::ST_ZONE;
				end else if (accept && req == pzsl_pkg::REQ_VEL) begin
					state_d = pzsl_pkg::ST_MUL;
				end
			end
			pzsl_pkg::ST_ZONE: begin
				if (need_div) begin
					state_d = pzsl_pkg::ST_DIV;
				end else if (zone_q == pzsl_pkg::ZN_RIGHT) begin
					state_d = pzsl_pkg::ST_IDLE;
				end
			end
			pzsl_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = (zone_q == pzsl_pkg::ZN_RIGHT) ? pzsl_pkg::ST_IDLE
					                                        : pzsl_pkg::ST_ZONE;
				end
			end
			pzsl_pkg::ST_MUL: begin
				if (mul_cnt_q == 2'd2) begin
					state_d = pzsl_pkg::ST_OUT;
				end
			end
			pzsl_pkg::ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = pzsl_pkg::ST_IDLE;
				end
			end
			default: state_d = pzsl_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start = 1'b0;
		upd_en    = 1'b0;
		upd_f     = '0;
		zone_adv  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			pzsl_pkg::ST_ZONE: begin
				if (!in_box) begin
					zone_adv = 1'b1;
				end else if (zero_hit) begin
					upd_en   = 1'b1;
					zone_adv = 1'b1;
				end else if (full_hit) begin
					upd_en   = 1'b1;
					upd_f    = FACTOR_ONE;
					zone_adv = 1'b1;
				end else begin
					div_start = 1'b1;
				end
			end
			pzsl_pkg::ST_DIV: begin
				if (div_done) begin
					upd_en   = 1'b1;
					upd_f    = {1'b0, div_quot};
					zone_adv = 1'b1;
				end
			end
			pzsl_pkg::ST_OUT: begin
				out_load = !m_valid_q || m_axis_tready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pzsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// zone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pzsl_pkg::ZONE_N; i++) begin
				zone_hit_q[i]    <= 1'b0;
				zone_factor_q[i] <= FACTOR_ONE;
			end
			zone_q <= '0;
		end else begin
			if (accept && req == pzsl_pkg::REQ_BEGIN) begin
				for (int i = 0; i < pzsl_pkg::ZONE_N; i++) begin
					zone_hit_q[i]    <= 1'b0;
					zone_factor_q[i] <= FACTOR_ONE;
				end
			end
			if (upd_en) begin
				zone_hit_q[zone_q] <= 1'b1;
				if (upd_f < zone_factor_q[zone_q]) begin
					zone_factor_q[zone_q] <= upd_f;
				end
			end
			if (accept) begin
				zone_q <= pzsl_pkg::ZN_FRONT;
			end else if (zone_adv) begin
				zone_q <= zone_q + 1'b1;
			end
		end
	end

	// factor selection for a velocity command
	always_comb begin
		fx = FACTOR_ONE;
		if (zone_hit_q[pzsl_pkg::ZN_FRONT] && !in_vx[VEL_W-1]) begin
			fx = zone_factor_q[pzsl_pkg::ZN_FRONT];
		end
		if (zone_hit_q[pzsl_pkg::ZN_REAR] && in_vx[VEL_W-1]) begin
			fx = zone_factor_q[pzsl_pkg::ZN_REAR];
		end
		fy = FACTOR_ONE;
		if (zone_hit_q[pzsl_pkg::ZN_LEFT] && !in_vy[VEL_W-1]) begin
			fy = zone_factor_q[pzsl_pkg::ZN_LEFT];
		end
		if (zone_hit_q[pzsl_pkg::ZN_RIGHT] && in_vy[VEL_W-1]) begin
			fy = zone_factor_q[pzsl_pkg::ZN_RIGHT];
		end
		fa = FACTOR_ONE;
		for (int i = 0; i < pzsl_pkg::ZONE_N; i++) begin
			if (zone_hit_q[i] && zone_factor_q[i] < fa) begin
				fa = zone_factor_q[i];
			end
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q  <= $signed(s_axis_tdata[15:0]);
			py_q  <= $signed(s_axis_tdata[31:16]);
			vx_q  <= in_vx;
			vy_q  <= in_vy;
			yaw_q <= $signed(s_axis_tdata[79:64]);
			fx_q  <= fx;
			fy_q  <= fy;
			fa_q  <= fa;
		end
	end

	// shared multiplier, one axis per cycle
	always_comb begin
		unique case (mul_cnt_q)
			2'd0: begin
				v_sel = vx_q;
				f_sel = fx_q;
			end
			2'd1: begin
				v_sel = vy_q;
				f_sel = fy_q;
			end
			default: begin
				v_sel = yaw_q;
				f_sel = fa_q;
			end
		endcase
		mag  = v_sel[VEL_W-1] ? VEL_W'(-v_sel) : VEL_W'(v_sel);
		prod = PW'(mag) * PW'(f_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
		end else if (accept) begin
			mul_cnt_q <= '0;
		end else if (state_q == pzsl_pkg::ST_MUL) begin
			mul_cnt_q <= mul_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pzsl_pkg::ST_MUL) begin
			mag_q[mul_cnt_q] <= prod[FACTOR_BITS +: VEL_W];
		end
	end

	// sign restore and result packing
	assign res_vx  = vx_q[VEL_W-1]  ? VEL_W'(-mag_q[0]) : mag_q[0];
	assign res_vy  = vy_q[VEL_W-1]  ? VEL_W'(-mag_q[1]) : mag_q[1];
	assign res_yaw = yaw_q[VEL_W-1] ? VEL_W'(-mag_q[2]) : mag_q[2];

	always_comb begin
		for (int i = 0; i < pzsl_pkg::ZONE_N; i++) begin
			hits[i] = zone_hit_q[i];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {4'b0000, hits, res_yaw, res_vy, res_vx};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the proximity zone speed limiter. Obstacle points,
// cloud starts and velocity commands are streamed in under random idling;
// an in-bench model of the four clearance boxes predicts each limited
// command, and every returned command is compared field by field.
// ----------------------------------------------------------------------------

module tb;
	import pzsl_pkg::*;

	localparam int FACTOR_BITS = 16;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 4 * (FACTOR_BITS + 3) + 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RAND_ITEMS = 600;
	localparam int RAND_PHASES = 6;
	localparam int STEADY_PHASE = 4;
	localparam int IDLE_PERCENT = 12;
	localparam int MAX_REPORTS = 30;
	localparam int REG_MAX = (1 << REG_W) - 1;
	localparam logic [FACTOR_BITS:0] FACTOR_ONE = {1'b1, {FACTOR_BITS{1'b0}}};
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_ZERO_DIST + 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE = '1;

	typedef struct packed {
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] yaw;
		logic [3:0]  hits;
	} limited_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [REG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// point_x, point_y, cmd_vx, cmd_vy, cmd_yaw
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// req_type
	logic [REQ_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// out_vx, out_vy, out_yaw, zone_hits, zero fill
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// model state: geometry and per-box hit flag and lowest factor
	int len_half, wid_half, slow_band, stop_band;
	bit box_seen [ZONE_N];
	logic [FACTOR_BITS:0] box_floor [ZONE_N];
	limited_cmd_t pending_cmds [$];

	bit steady = 1'b0;
	int errors = 0;
	int items_sent = 0;
	int n_points = 0;
	int n_cmds = 0;
	int n_checked = 0;
	int n_geometries = 0;

	proximity_zone_speed_limiter #(
		.FACTOR_BITS(FACTOR_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// clock
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ---------------- prediction ----------------

	function automatic void boxes_reset();
		for (int i = 0; i < ZONE_N; i++) begin
			box_seen[i] = 1'b0;
			box_floor[i] = FACTOR_ONE;
		end
	endfunction

	// zero at or inside the stop band, one at or past the slow band, linear between
	function automatic logic [FACTOR_BITS:0] speed_factor_at(int d);
		longint q;
		if (d <= stop_band)
			return '0;
		if (d >= slow_band)
			return FACTOR_ONE;
		q = (longint'(d - stop_band) << FACTOR_BITS) / longint'(slow_band - stop_band);
		return q[FACTOR_BITS:0];
	endfunction

	function automatic void box_note(logic [1:0] z, int d);
		logic [FACTOR_BITS:0] f;
		f = speed_factor_at(d);
		box_seen[z] = 1'b1;
		if (f < box_floor[z])
			box_floor[z] = f;
	endfunction

	// a point may land in several boxes, each is updated
	function automatic void boxes_take_point(int x, int y);
		bit x_body, y_body;
		x_body = (x >= -len_half) && (x <= len_half);
		y_body = (y >= -wid_half) && (y <= wid_half);
		if (x >= len_half && x <= len_half + slow_band && y_body)
			box_note(ZN_FRONT, x - len_half);
		if (x >= -len_half - slow_band && x <= -len_half && y_body)
			box_note(ZN_REAR, -len_half - x);
		if (x_body && y >= wid_half && y <= wid_half + slow_band)
			box_note(ZN_LEFT, y - wid_half);
		if (x_body && y >= -wid_half - slow_band && y <= -wid_half)
			box_note(ZN_RIGHT, -wid_half - y);
	endfunction

	// magnitude times factor, truncated, sign put back
	function automatic logic [15:0] scale_speed(logic signed [15:0] v, logic [FACTOR_BITS:0] f);
		longint mag;
		mag = longint'(v);
		if (mag < 0)
			mag = -mag;
		mag = (mag * longint'(f)) >> FACTOR_BITS;
		if (v < 0)
			mag = -mag;
		return mag[15:0];
	endfunction

	function automatic limited_cmd_t limit_command(logic signed [15:0] vx, logic signed [15:0] vy,
			logic signed [15:0] yaw);
		logic [FACTOR_BITS:0] fx, fy, fa;
		limited_cmd_t r;
		fx = FACTOR_ONE;
		fy = FACTOR_ONE;
		fa = FACTOR_ONE;
		r.hits = '0;
		if (box_seen[ZN_FRONT] && vx >= 0)
			fx = box_floor[ZN_FRONT];
		if (box_seen[ZN_REAR] && vx < 0)
			fx = box_floor[ZN_REAR];
		if (box_seen[ZN_LEFT] && vy >= 0)
			fy = box_floor[ZN_LEFT];
		if (box_seen[ZN_RIGHT] && vy < 0)
			fy = box_floor[ZN_RIGHT];
		for (int i = 0; i < ZONE_N; i++) begin
			if (box_seen[i]) begin
				r.hits[i] = 1'b1;
				if (box_floor[i] < fa)
					fa = box_floor[i];
			end
		end
		r.vx = scale_speed(vx, fx);
		r.vy = scale_speed(vy, fy);
		r.yaw = scale_speed(yaw, fa);
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic int rand_between(int lo, int hi);
		int v;
		v = lo + int'($urandom_range(hi - lo));
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return v;
	endfunction

	function automatic logic [15:0] random_speed();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(2000));
			4: return -16'($urandom_range(2000));
			default: return rnd16();
		endcase
	endfunction

	// one request, with random idle cycles ahead of it; predicted on acceptance
	task automatic send_request(logic [REQ_W-1:0] kind, logic [15:0] x, logic [15:0] y,
			logic [15:0] vx, logic [15:0] vy, logic [15:0] yaw);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {yaw, vy, vx, y, x};
		do
			@(posedge clk);
		while (!s_axis_tready);
		case (kind)
			REQ_BEGIN: boxes_reset();
			REQ_POINT: begin
				boxes_take_point(int'($signed(x)), int'($signed(y)));
				n_points++;
			end
			REQ_VEL: begin
				pending_cmds.insert(pending_cmds.size(), limit_command(vx, vy, yaw));
				n_cmds++;
			end
			default: ;
		endcase
		if (kind != REQ_SPARE)
			items_sent++;
	endtask

	task automatic send_begin();
		send_request(REQ_BEGIN, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
	endtask

	task automatic send_point(logic [15:0] x, logic [15:0] y);
		send_request(REQ_POINT, x, y, rnd16(), rnd16(), rnd16());
	endtask

	task automatic send_command(logic [15:0] vx, logic [15:0] vy, logic [15:0] yaw);
		send_request(REQ_VEL, rnd16(), rnd16(), vx, vy, yaw);
	endtask

	// wait for every result, then let a slow point finish before touching registers
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic drive_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_geometry(int hl, int hw, int rd, int zd);
		drain();
		drive_reg(CFG_HALF_LENGTH, hl[REG_W-1:0]);
		drive_reg(CFG_HALF_WIDTH, hw[REG_W-1:0]);
		drive_reg(CFG_REDUCE_DIST, rd[REG_W-1:0]);
		drive_reg(CFG_ZERO_DIST, zd[REG_W-1:0]);
		// an index past the register map must change nothing
		drive_reg(CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)),
			REG_W'($urandom));
		cfg_we <= 1'b0;
		len_half = hl & REG_MAX;
		wid_half = hw & REG_MAX;
		slow_band = rd & REG_MAX;
		stop_band = zd & REG_MAX;
		n_geometries++;
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch in %s: got %h, expected %h (result %0d)",
				what, got, want, n_checked);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	always @(posedge clk) begin
		limited_cmd_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[15:0], '0);
			end else begin
				want = pending_cmds.pop_front();
				if (m_axis_tdata[15:0] !== want.vx)
					report_mismatch("out_vx", m_axis_tdata[15:0], want.vx);
				if (m_axis_tdata[31:16] !== want.vy)
					report_mismatch("out_vy", m_axis_tdata[31:16], want.vy);
				if (m_axis_tdata[47:32] !== want.yaw)
					report_mismatch("out_yaw", m_axis_tdata[47:32], want.yaw);
				if (m_axis_tdata[51:48] !== want.hits)
					report_mismatch("zone_hits", 16'(m_axis_tdata[51:48]), 16'(want.hits));
			end
			n_checked++;
		end
	end

	// ---------------- tests ----------------

	// reset geometry, no cloud at first: boxes hold their reset values until a front point lands
	task automatic test_reset_state();
		send_command(16'h7fff, 16'h8000, 16'h8000);
		// unused request kind shaped like a front point: must be ignored
		send_request(REQ_SPARE, 16'd300, 16'd0, rnd16(), rnd16(), rnd16());
		send_command(16'd1000, 16'd1000, 16'd1000);
		send_point(16'd600, 16'd0);
		send_command(16'd1000, -16'sd1000, 16'h8000);
	endtask

	// inclusive edges of every box, a corner point in two boxes, mid-band factors
	task automatic test_box_edges();
		send_begin();
		send_point(16'd250, 16'd0);
		send_point(16'd750, 16'd200);
		send_point(-16'sd750, -16'sd200);
		send_point(-16'sd250, -16'sd200);
		send_point(16'd0, 16'd700);
		send_point(16'd0, 16'd701);
		send_point(16'd751, 16'd0);
		send_point(16'd600, 16'd0);
		send_point(-16'sd10, 16'd450);
		send_command(16'd1000, 16'd1000, 16'd1000);
		send_command(-16'sd1000, -16'sd1000, 16'h8000);
		send_command(16'h7fff, -16'sd32767, 16'h7fff);
	endtask

	// zero distance above reduce distance: every clearance gives factor zero
	task automatic test_distance_order();
		load_geometry(10, 10, 40, 60);
		send_begin();
		send_point(16'd50, 16'd0);
		send_point(-16'sd10, -16'sd10);
		send_point(16'd0, 16'd30);
		send_command(16'd500, -16'sd500, 16'd500);
	endtask

	// registers at both ends, coordinates at both ends
	task automatic test_register_extremes();
		load_geometry(REG_MAX, REG_MAX, REG_MAX, 0);
		send_begin();
		send_point(16'd16382, 16'd0);
		send_point(16'h7fff, 16'h7fff);
		send_point(-16'sd16382, -16'sd8191);
		send_point(16'h8000, 16'd0);
		send_point(16'd0, -16'sd16382);
		send_point(16'd0, 16'd8192);
		send_command(16'h8000, 16'h7fff, 16'h8000);
		load_geometry(0, 0, 0, 0);
		send_begin();
		send_point(16'd0, 16'd0);
		send_command(16'h7fff, 16'h8000, 16'h7fff);
	endtask

	task automatic random_geometry(int phase);
		int hl, hw, rd, zd;
		hl = $urandom_range(400);
		hw = $urandom_range(400);
		rd = $urandom_range(600, 20);
		zd = $urandom_range(rd);
		case (phase)
			1: zd = rd + $urandom_range(200);
			2: begin
				hl = REG_MAX;
				hw = $urandom_range(REG_MAX);
				rd = REG_MAX;
				zd = $urandom_range(REG_MAX);
			end
			5: begin
				hl = 0;
				hw = 0;
			end
			default: ;
		endcase
		load_geometry(hl, hw, rd, zd);
	endtask

	// one cloud: mostly points near the boxes, some stray points, then commands
	task automatic send_cloud();
		int n_pts, n_vel, x, y;
		n_pts = $urandom_range(8, 1);
		n_vel = $urandom_range(3, 1);
		// now and then the previous cloud carries over
		if ($urandom_range(9) != 0)
			send_begin();
		repeat (n_pts) begin
			if ($urandom_range(9) < 8) begin
				case (2'($urandom_range(ZONE_N - 1)))
					ZN_FRONT: begin
						x = rand_between(len_half - 2, len_half + slow_band + 2);
						y = rand_between(-wid_half - 2, wid_half + 2);
					end
					ZN_REAR: begin
						x = rand_between(-len_half - slow_band - 2, -len_half + 2);
						y = rand_between(-wid_half - 2, wid_half + 2);
					end
					ZN_LEFT: begin
						x = rand_between(-len_half - 2, len_half + 2);
						y = rand_between(wid_half - 2, wid_half + slow_band + 2);
					end
					default: begin
						x = rand_between(-len_half - 2, len_half + 2);
						y = rand_between(-wid_half - slow_band - 2, -wid_half + 2);
					end
				endcase
				send_point(x[15:0], y[15:0]);
			end else begin
				send_point(rnd16(), rnd16());
			end
			if ($urandom_range(29) == 0)
				send_request(REQ_SPARE, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
		end
		repeat (n_vel) send_command(random_speed(), random_speed(), random_speed());
	endtask

	task automatic test_random_clouds();
		int quota;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			random_geometry(phase);
			// one phase runs with neither side idling
			steady = (phase == STEADY_PHASE);
			quota = items_sent + RAND_ITEMS / RAND_PHASES;
			while (items_sent < quota)
				send_cloud();
		end
		steady = 1'b0;
	endtask

	// ---------------- sequence ----------------

	initial begin
		len_half = int'(RST_HALF_LENGTH);
		wid_half = int'(RST_HALF_WIDTH);
		slow_band = int'(RST_REDUCE_DIST);
		stop_band = int'(RST_ZERO_DIST);
		boxes_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_box_edges();
		test_distance_order();
		test_register_extremes();
		test_random_clouds();
		drain();
		$display("covered %0d requests: %0d obstacle points and %0d velocity commands",
			items_sent, n_points, n_cmds);
		$display("checked %0d limited commands over %0d geometry settings, %0d mismatches",
			n_checked, n_geometries, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results outstanding", pending_cmds.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
